@@ hdl/spl_pkg.sv @@
// Shared constants, codes and request/response types of the stable sorted priority list.
`timescale 1ns / 1ps
package spl_pkg;

  localparam int CAPACITY   = 128;
  localparam int ID_W       = 32;
  localparam int PRIO_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int POSITION_W = 7;
  localparam int COUNT_W    = 8;

  localparam int POS_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // hit search: groups of eight cells, eight groups examined per scan step
  localparam int GRP_SIZE    = 8;
  localparam int NUM_GRP     = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
  localparam int NUM_STEP    = (NUM_GRP + 7) / 8;
  localparam int NUM_GRP_PAD = NUM_STEP * 8;
  localparam int STEP_W      = (NUM_STEP > 1) ? $clog2(NUM_STEP) : 1;
  localparam int RAW_W       = STEP_W + 6;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [ID_W-1:0]   item_id;
    logic [PRIO_W-1:0] item_priority;
  } spl_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [POSITION_W-1:0] position;
    logic [COUNT_W-1:0]    entry_count;
  } spl_rsp_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } spl_entry_t;

  typedef struct packed {
    logic              en;
    logic              op;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } spl_cmp_t;

  typedef struct packed {
    logic             en;
    logic             op;
    logic [POS_W-1:0] pos;
  } spl_upd_t;

endpackage

@@ hdl/spl_cell.sv @@
// One list slot: holds an entry, compares it with the request and shifts with its neighbours.
`timescale 1ns / 1ps
module spl_cell import spl_pkg::*; (
  input  logic             clk_i,
  input  logic [POS_W-1:0] slot_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  spl_cmp_t         cmp_i,
  input  spl_upd_t         upd_i,
  input  spl_entry_t       left_i,
  input  spl_entry_t       right_i,
  input  spl_entry_t       new_i,
  output spl_entry_t       ent_o,
  output logic             hit_o
);

  spl_entry_t ent_q, ent_d;
  logic       hit_q, hit_d;
  logic       occ;

  assign occ = CNT_W'(slot_i) < cnt_i;

  always_comb begin
    // insert looks for the first slot that is empty or holds a larger priority
    if (cmp_i.op == OP_INSERT) begin
      hit_d = !(occ && (ent_q.prio <= cmp_i.prio));
    end else begin
      hit_d = occ && (ent_q.id == cmp_i.id);
    end
  end

  always_comb begin
    ent_d = ent_q;
    if (upd_i.en) begin
      if (upd_i.op == OP_INSERT) begin
        if (slot_i > upd_i.pos) begin
          ent_d = left_i;
        end else if (slot_i == upd_i.pos) begin
          ent_d = new_i;
        end
      end else if (slot_i >= upd_i.pos) begin
        ent_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    if (cmp_i.en) begin
      hit_q <= hit_d;
    end
  end

  assign ent_o = ent_q;
  assign hit_o = hit_q;

endmodule

@@ hdl/spl_locate.sv @@
// First-hit search over the cell flags: group summaries, then a shifting scan.
`timescale 1ns / 1ps
module spl_locate import spl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [CAPACITY-1:0] hit_i,
  output logic                done_o,
  output logic                found_o,
  output logic [POS_W-1:0]    pos_o
);

  localparam logic LS_IDLE = 1'b0;
  localparam logic LS_SCAN = 1'b1;

  logic                          state_q, state_d;
  logic                          done_q, done_d;
  logic                          found_q, found_d;
  logic [POS_W-1:0]              pos_q, pos_d;
  logic [STEP_W-1:0]             step_q, step_d;
  logic [NUM_GRP_PAD-1:0]        grp_any_q, grp_any_d, load_any;
  logic [2:0]                    grp_idx_q [NUM_GRP_PAD];
  logic [2:0]                    grp_idx_d [NUM_GRP_PAD];
  logic [2:0]                    load_idx  [NUM_GRP_PAD];
  logic [NUM_GRP_PAD*GRP_SIZE-1:0] hit_pad;
  logic                          sel_found;
  logic [2:0]                    sel_g, sel_idx;
  logic [RAW_W-1:0]              raw_pos;

  assign hit_pad = (NUM_GRP_PAD*GRP_SIZE)'(hit_i);

  always_comb begin
    for (int g = 0; g < NUM_GRP_PAD; g++) begin
      load_any[g] = |hit_pad[g*GRP_SIZE +: GRP_SIZE];
      load_idx[g] = 3'd0;
      for (int b = GRP_SIZE - 1; b >= 0; b--) begin
        if (hit_pad[g*GRP_SIZE + b]) begin
          load_idx[g] = 3'(b);
        end
      end
    end
  end

  // lowest of the eight groups at the head of the shift line
  always_comb begin
    sel_found = 1'b0;
    sel_g     = 3'd0;
    sel_idx   = 3'd0;
    for (int g = 7; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        sel_found = 1'b1;
        sel_g     = 3'(g);
        sel_idx   = grp_idx_q[g];
      end
    end
  end

  assign raw_pos = {step_q, sel_g, sel_idx};

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    found_d   = found_q;
    pos_d     = pos_q;
    step_d    = step_q;
    grp_any_d = grp_any_q;
    grp_idx_d = grp_idx_q;
    if (start_i) begin
      state_d   = LS_SCAN;
      step_d    = '0;
      grp_any_d = load_any;
      grp_idx_d = load_idx;
    end else if (state_q == LS_SCAN) begin
      if (sel_found) begin
        found_d = 1'b1;
        pos_d   = raw_pos[POS_W-1:0];
        done_d  = 1'b1;
        state_d = LS_IDLE;
      end else if (step_q == STEP_W'(NUM_STEP - 1)) begin
        found_d = 1'b0;
        pos_d   = '0;
        done_d  = 1'b1;
        state_d = LS_IDLE;
      end else begin
        // advance the group line by eight groups
        for (int g = 0; g < NUM_GRP_PAD; g++) begin
          if (g + 8 < NUM_GRP_PAD) begin
            grp_any_d[g] = grp_any_q[g + 8];
            grp_idx_d[g] = grp_idx_q[g + 8];
          end else begin
            grp_any_d[g] = 1'b0;
            grp_idx_d[g] = 3'd0;
          end
        end
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= LS_IDLE;
      done_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    step_q    <= step_d;
    grp_any_q <= grp_any_d;
    grp_idx_q <= grp_idx_d;
  end

  assign done_o  = done_q;
  assign found_o = found_q;
  assign pos_o   = pos_q;

endmodule

@@ hdl/stable_priority_sorted_list.sv @@
// Top level of the stable sorted priority list: cell row, hit search and request control.
// A request passes through the compare, search load, search wait and finish states; the search
// takes one more scan step for each further 64 slots beyond slots 0 to 63.
// No new request is taken before the result is registered; output stalls delay that.
// Reset: asynchronous, active low; clears the entry count and control, so the list is empty.
// Entry contents are not reset; slots at or above the count are never looked at.
`timescale 1ns / 1ps
module stable_priority_sorted_list import spl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  spl_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output spl_rsp_t out_rsp_o
);

  // request sequencing: capture, compare in every cell, load the search, wait, finish
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CMP  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]          state_q, state_d;
  spl_req_t            req_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  spl_rsp_t            rsp_q, rsp_d;

  logic                accept, fire;
  logic                is_ins, full, ok;
  logic                loc_done, loc_found;
  logic [POS_W-1:0]    loc_pos, pos_fin;
  logic [CAPACITY-1:0] hit;
  logic [31:0]         pos_ext, cnt_ext;

  spl_cmp_t            cmp;
  spl_upd_t            upd;
  spl_entry_t          new_ent;
  spl_entry_t          ent [CAPACITY];

  assign accept = in_valid_i && !in_stall_o;
  // hold new requests until the current one has been written to the output register
  assign in_stall_o = (state_q != ST_IDLE);
  assign fire = (state_q == ST_FIN) && (!out_valid_q || !out_stall_i);

  assign is_ins = (req_q.operation == OP_INSERT);
  assign full   = (cnt_q == CNT_W'(CAPACITY));
  // a non-full insert always hits: the slot at the count is empty
  assign ok     = is_ins ? !full : loc_found;

  assign cmp.en   = (state_q == ST_CMP);
  assign cmp.op   = req_q.operation;
  assign cmp.id   = req_q.item_id;
  assign cmp.prio = req_q.item_priority;

  assign upd.en  = fire && ok;
  assign upd.op  = req_q.operation;
  assign upd.pos = loc_pos;

  assign new_ent.id   = req_q.item_id;
  assign new_ent.prio = req_q.item_priority;

  // row of cells: each one takes from its left neighbour on insert, its right on remove
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spl_entry_t left_ent, right_ent;
    if (i == 0) begin : g_first
      assign left_ent = '0;
    end else begin : g_mid_l
      assign left_ent = ent[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid_r
      assign right_ent = ent[i+1];
    end

    spl_cell u_cell (
      .clk_i   (clk_i),
      .slot_i  (POS_W'(i)),
      .cnt_i   (cnt_q),
      .cmp_i   (cmp),
      .upd_i   (upd),
      .left_i  (left_ent),
      .right_i (right_ent),
      .new_i   (new_ent),
      .ent_o   (ent[i]),
      .hit_o   (hit[i])
    );
  end

  spl_locate u_locate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_LOAD),
    .hit_i   (hit),
    .done_o  (loc_done),
    .found_o (loc_found),
    .pos_o   (loc_pos)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP:  state_d = ST_LOAD;
      ST_LOAD: state_d = ST_WAIT;
      ST_WAIT: begin
        if (loc_done) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // result fields; narrow or widen the internal position and count to the port widths
  assign pos_fin = ok ? loc_pos : '0;

  always_comb begin
    cnt_d = cnt_q;
    if (upd.en) begin
      cnt_d = is_ins ? cnt_q + 1'b1 : cnt_q - 1'b1;
    end
  end

  assign pos_ext = 32'(pos_fin);
  assign cnt_ext = 32'(cnt_d);

  always_comb begin
    rsp_d.position    = pos_ext[POSITION_W-1:0];
    rsp_d.entry_count = cnt_ext[COUNT_W-1:0];
    if (ok) begin
      rsp_d.status = ST_DONE;
    end else if (is_ins) begin
      rsp_d.status = ST_FULL;
    end else begin
      rsp_d.status = ST_NOT_FOUND;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_req_i;
    end
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_ins_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && loc_done && is_ins && !full) |-> loc_found)
    else $error("insert into a non-full list found no slot");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> cnt_q == $past(cnt_q))
    else $error("entry count changed without a finished request");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fire))
    else $error("result appeared without a finished request");

endmodule

@@ test/tb_stable_priority_sorted_list.sv @@
// Self-checking testbench for the stable sorted priority list: directed rows, then random requests against a predictor.
`timescale 1ns / 1ps
module tb_stable_priority_sorted_list;
  import spl_pkg::*;

  localparam int  HOLD_CYCLES = 300;        // length of a long receiver hold-off
  localparam int  MIX_ITEMS   = 280;        // mixed requests per round
  localparam int  PRINT_LIMIT = 40;         // mismatch lines printed before going quiet
  localparam time RUN_LIMIT   = 6_000_000;  // ns, several times the slowest correct run

  typedef enum logic [1:0] {PH_MIX, PH_FILL, PH_DRAIN} load_phase_e;

  typedef struct {
    spl_req_t req;
    bit       has_rsp;
    spl_rsp_t rsp;
  } stim_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  spl_req_t in_req    = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  spl_rsp_t out_rsp;

  // Shadow copy of the list, kept in step with every accepted request
  logic [ID_W-1:0]   shadow_id   [CAPACITY];
  logic [PRIO_W-1:0] shadow_prio [CAPACITY];
  int                shadow_fill = 0;

  spl_rsp_t  awaited_rsp_q [$];
  spl_rsp_t  awaited_head;
  stim_row_t directed_rows [$];

  bit quiet      = 1'b0;  // no idling on either side while set
  int hold_asks  = 0;
  int holds_done = 0;
  int hold_left  = 0;

  int mismatch_count  = 0;
  int requests_sent   = 0;
  int results_checked = 0;
  int insert_count    = 0;
  int remove_count    = 0;
  int full_count      = 0;
  int absent_count    = 0;
  int peak_fill       = 0;

  stable_priority_sorted_list DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  always #6 clk = ~clk;

  initial begin : run_limit
    #(RUN_LIMIT);
    $display("timeout: %0d requests sent, %0d results outstanding", requests_sent,
             awaited_rsp_q.size());
    $display("simulation failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("%0t ns: mismatch, %s", $time, msg);
    mismatch_count++;
  endtask

  // Apply one request to the shadow list and return the response it must give.
  // Inserts go after every entry of lower or equal priority, so ties keep arrival order;
  // removes take the lowest-position match and close the gap.
  function automatic spl_rsp_t sorted_list_update(input spl_req_t req);
    spl_rsp_t rsp;
    int       slot;
    rsp.status      = ST_DONE;
    rsp.position    = '0;
    slot            = 0;
    if (req.operation == OP_INSERT) begin
      insert_count++;
      if (shadow_fill >= CAPACITY) begin
        rsp.status = ST_FULL;
        full_count++;
      end else begin
        while (slot < shadow_fill && shadow_prio[slot] <= req.item_priority) slot++;
        for (int k = shadow_fill; k > slot; k--) begin
          shadow_id[k]   = shadow_id[k-1];
          shadow_prio[k] = shadow_prio[k-1];
        end
        shadow_id[slot]   = req.item_id;
        shadow_prio[slot] = req.item_priority;
        shadow_fill++;
        rsp.position = POSITION_W'(slot);
      end
    end else begin
      remove_count++;
      while (slot < shadow_fill && shadow_id[slot] != req.item_id) slot++;
      if (slot >= shadow_fill) begin
        rsp.status = ST_NOT_FOUND;
        absent_count++;
      end else begin
        for (int k = slot; k + 1 < shadow_fill; k++) begin
          shadow_id[k]   = shadow_id[k+1];
          shadow_prio[k] = shadow_prio[k+1];
        end
        shadow_fill--;
        rsp.position = POSITION_W'(slot);
      end
    end
    rsp.entry_count = COUNT_W'(shadow_fill);
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    return rsp;
  endfunction

  // Draw a random request shaped by the load phase. Priorities cluster on a few small
  // values so that ties are common; removes mostly name an identifier that is held.
  function automatic spl_req_t pick_request(input load_phase_e phase);
    spl_req_t req;
    int       roll;
    roll = $urandom_range(0, 99);
    case (phase)
      PH_MIX:  req.operation = (roll < 55) ? OP_INSERT : OP_REMOVE;
      PH_FILL: req.operation = (roll < 90) ? OP_INSERT : OP_REMOVE;
      default: req.operation = (roll < 90) ? OP_REMOVE : OP_INSERT;
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 40)      req.item_priority = PRIO_W'($urandom_range(0, 7));
    else if (roll < 45) req.item_priority = {PRIO_W{1'b0}};
    else if (roll < 50) req.item_priority = {PRIO_W{1'b1}};
    else                req.item_priority = $urandom;
    roll = $urandom_range(0, 99);
    if (req.operation == OP_REMOVE && shadow_fill > 0 && roll < 80)
      req.item_id = shadow_id[$urandom_range(0, shadow_fill - 1)];
    else if (roll < 90)
      req.item_id = ID_W'($urandom_range(0, 15));  // small pool, so duplicates occur
    else
      req.item_id = $urandom;
    return req;
  endfunction

  function automatic void add_row(input logic op, input logic [ID_W-1:0] id,
                                  input logic [PRIO_W-1:0] prio, input bit has_rsp,
                                  input logic [STATUS_W-1:0] st,
                                  input logic [POSITION_W-1:0] pos,
                                  input logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row.req.operation     = op;
    row.req.item_id       = id;
    row.req.item_priority = prio;
    row.has_rsp           = has_rsp;
    row.rsp.status        = st;
    row.rsp.position      = pos;
    row.rsp.entry_count   = cnt;
    directed_rows.push_back(row);
  endfunction

  // Offer one request and hold it until taken, then record what it must return.
  // Idle afterwards now and then; never lower and raise valid in one step.
  task automatic offer(input spl_req_t req, input bit has_rsp, input spl_rsp_t typed_rsp);
    spl_rsp_t predicted;
    in_req   <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = sorted_list_update(req);
    awaited_rsp_q.push_back(has_rsp ? typed_rsp : predicted);
    requests_sent++;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Receiver: long hold-offs on request, random stalls otherwise, none while quiet
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (holds_done < hold_asks) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 15);
    end
  end

  // Compare each taken result with the oldest outstanding expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_rsp_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                  results_checked));
      end else begin
        awaited_head = awaited_rsp_q.pop_front();
        if (out_rsp.status !== awaited_head.status)
          report_mismatch($sformatf("result %0d status %0d, expected %0d", results_checked,
                                    out_rsp.status, awaited_head.status));
        if (out_rsp.position !== awaited_head.position)
          report_mismatch($sformatf("result %0d position %0d, expected %0d", results_checked,
                                    out_rsp.position, awaited_head.position));
        if (out_rsp.entry_count !== awaited_head.entry_count)
          report_mismatch($sformatf("result %0d count %0d, expected %0d", results_checked,
                                    out_rsp.entry_count, awaited_head.entry_count));
      end
      results_checked++;
    end
  end

  initial begin : stimulus
    spl_rsp_t no_rsp;
    no_rsp = '0;

    // Directed rows: empty list, extremes, stable ties, duplicate identifiers, absent ids
    add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1, ST_NOT_FOUND, 7'd0, 8'd0);
    add_row(OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1, ST_DONE,      7'd0, 8'd1);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, ST_DONE,      7'd1, 8'd2);
    add_row(OP_INSERT, 32'h0000_0005, 32'h0000_0000, 1, ST_DONE,      7'd1, 8'd3);
    add_row(OP_INSERT, 32'h0000_0007, 32'hFFFF_FFFF, 1, ST_DONE,      7'd3, 8'd4);
    add_row(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_INSERT, 32'h0000_0000, 32'h8000_0000, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_INSERT, 32'h0000_0009, 32'h5555_5555, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_INSERT, 32'h0000_0000, 32'h0000_0001, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_REMOVE, 32'h0000_0000, 32'h1234_5678, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_REMOVE, 32'hFFFF_FFFF, 32'h1234_5678, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_REMOVE, 32'h0000_0007, 32'h0000_0000, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_REMOVE, 32'h0000_0005, 32'h0000_0000, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_REMOVE, 32'h8000_0000, 32'h0000_0000, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, 0, ST_DONE, 7'd0, 8'd0);
    add_row(OP_REMOVE, 32'h0000_0009, 32'h0000_0000, 0, ST_DONE, 7'd0, 8'd0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (directed_rows[i])
      offer(directed_rows[i].req, directed_rows[i].has_rsp, directed_rows[i].rsp);

    // Each round: mixed traffic, fill to capacity and push against it, then drain
    for (int round = 0; round < 2; round++) begin
      for (int i = 0; i < MIX_ITEMS; i++) begin
        if (round == 0 && i == 100) hold_asks++;
        offer(pick_request(PH_MIX), 1'b0, no_rsp);
      end
      quiet = (round == 1);
      while (shadow_fill < CAPACITY) offer(pick_request(PH_FILL), 1'b0, no_rsp);
      for (int i = 0; i < 24; i++) offer(pick_request(PH_MIX), 1'b0, no_rsp);
      quiet = 1'b0;
      if (round == 1) hold_asks++;
      while (shadow_fill > 0) offer(pick_request(PH_DRAIN), 1'b0, no_rsp);
    end
    in_valid <= 1'b0;

    while (awaited_rsp_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d requests (%0d inserts, %0d removes), %0d results checked, peak fill %0d of %0d",
             requests_sent, insert_count, remove_count, results_checked, peak_fill, CAPACITY);
    $display("%0d inserts refused on a full list, %0d removes of identifiers not held",
             full_count, absent_count);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/spl_pkg.sv
hdl/spl_cell.sv
hdl/spl_locate.sv
hdl/stable_priority_sorted_list.sv
test/tb_stable_priority_sorted_list.sv
